// ===== rtl/core/tso_pkg.sv =====
// Package: types, constants and codes of the store buffer memory core.
package tso_pkg;

	localparam int THREADS_DEF      = 4;
	localparam int BUFFER_DEPTH_DEF = 8;
	localparam int MEMORY_CELLS_DEF = 256;
	localparam int VALUE_BITS_DEF   = 64;

	// Request actions
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_PROP  = 2'd2;
	localparam logic [1:0] ACT_FENCE = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  thread;
		logic [7:0]  address;
		logic [63:0] store_value;
		logic        seq_cst;
	} tso_req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        forwarded;
		logic [1:0]  status;
	} tso_rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_MEM,
		S_RD_SCAN,
		S_RD_WAIT,
		S_RD_CMP,
		S_WR,
		S_POP_RD,
		S_POP_WAIT,
		S_POP_WR,
		S_DONE
	} tso_state_t;

endpackage

// ===== rtl/core/tso_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module tso_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/tso_store_buffer_memory_core.sv =====
// Top level: TSO shared memory with per-thread FIFO store buffers.
//
// Usage: drive req and pulse start while busy is low; the request is taken
// at that edge and busy rises. Exactly one result appears on rsp for one
// cycle with done high; busy stays high through that cycle and falls in the
// next, whose closing edge may take the next request. The receiver cannot
// stall. States passed from the accepting edge up to S_DONE, the result:
//   write or rejected write: S_WR; propagate: S_POP_RD, S_POP_WAIT,
//   S_POP_WR; propagate on empty buffer: none; read: S_RD_MEM, S_RD_SCAN
//   and per buffer entry scanned S_RD_WAIT, S_RD_CMP, S_RD_SCAN, a match
//   at S_RD_CMP ending the scan (one compare per entry through the single
//   read port of the buffer RAM, youngest first); fence, or seq_cst write
//   after S_WR: S_POP_RD, S_POP_WAIT, S_POP_WR per drained entry and
//   S_POP_RD per empty thread slot visited, since all moves share the
//   memory write port. The block takes no new request while busy.
// Reset: buffer heads and counts clear at once; then a clearing pass
// zeroes each cell of the shared memory in turn, with busy high throughout.
// A buffer entry is only read while it is valid, so the buffer RAMs are
// not cleared.
module tso_store_buffer_memory_core
	import tso_pkg::*;
#(
	parameter int THREADS      = THREADS_DEF,
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int MEMORY_CELLS = MEMORY_CELLS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  tso_req_t req,
	output logic     busy,
	output logic     done,
	output tso_rsp_t rsp
);
	localparam int TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int DW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW  = $clog2(BUFFER_DEPTH + 1);
	localparam int MW  = $clog2(MEMORY_CELLS);
	localparam int BD  = THREADS * (2 ** DW);
	localparam int BW  = TW + DW;

	tso_state_t state_q, state_d;

	logic [TW-1:0]         thr_q;
	logic                  thr_ok_q;
	logic [MW-1:0]         cell_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  drain_q;   // current pops are part of a drain
	logic                  any_q;     // a pop happened in this drain round
	logic [CW-1:0]         k_q;
	logic [MW-1:0]         clr_q;
	logic [VALUE_BITS-1:0] data_q;
	logic                  fwd_q;
	logic [1:0]            st_q;

	logic [DW-1:0] head_q [THREADS];
	logic [CW-1:0] cnt_q  [THREADS];

	// memory and buffer ports
	logic                  mem_we, buf_we;
	logic [MW-1:0]         mem_waddr, mem_raddr;
	logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;
	logic [BW-1:0]         buf_waddr, buf_raddr;
	logic [MW+VALUE_BITS-1:0] buf_wdata, buf_rdata;

	tso_ram #(.WIDTH(VALUE_BITS), .DEPTH(MEMORY_CELLS)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	tso_ram #(.WIDTH(MW + VALUE_BITS), .DEPTH(BD)) u_buf (
		.clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
		.raddr(buf_raddr), .rdata(buf_rdata)
	);

	// request decode
	logic          in_thr_ok;
	logic [TW-1:0] in_thr;
	logic [MW-1:0] in_cell;
	assign in_thr    = TW'(req.thread);
	assign in_thr_ok = 32'(req.thread) < THREADS;
	assign in_cell   = MW'(req.address);

	logic [CW-1:0] cur_cnt;
	logic [DW-1:0] cur_head;
	logic          cur_full;
	assign cur_cnt  = cnt_q[thr_q];
	assign cur_head = head_q[thr_q];
	assign cur_full = (cur_cnt == CW'(BUFFER_DEPTH));

	// slot index = (head + offset) mod depth
	function automatic logic [DW-1:0] wrap(input logic [DW-1:0] h, input logic [CW-1:0] o);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(o);
		if (s >= (CW+1)'(BUFFER_DEPTH)) s = s - (CW+1)'(BUFFER_DEPTH);
		return DW'(s);
	endfunction

	logic last_thr;
	assign last_thr = (32'(thr_q) == THREADS - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (32'(clr_q) == MEMORY_CELLS - 1) state_d = S_IDLE;
			S_IDLE: if (start) begin
				case (req.action)
					ACT_READ:  state_d = S_RD_MEM;
					ACT_WRITE: state_d = S_WR;
					ACT_PROP:  state_d = (in_thr_ok && cnt_q[in_thr] != '0)
						? S_POP_RD : S_DONE;
					default:   state_d = S_POP_RD;
				endcase
			end
			S_RD_MEM:  state_d = S_RD_SCAN;
			S_RD_SCAN: state_d = (thr_ok_q && k_q != '0) ? S_RD_WAIT : S_DONE;
			S_RD_WAIT: state_d = S_RD_CMP;
			S_RD_CMP:  state_d = (buf_rdata[MW+VALUE_BITS-1:VALUE_BITS] == cell_q)
				? S_DONE : S_RD_SCAN;
			S_WR: state_d = (!thr_ok_q || cur_full || !drain_q) ? S_DONE : S_POP_RD;
			S_POP_RD: begin
				if (cur_cnt != '0) state_d = S_POP_WAIT;
				else if (last_thr && !any_q) state_d = S_DONE;
			end
			S_POP_WAIT: state_d = S_POP_WR;
			S_POP_WR: begin
				if (!drain_q) state_d = S_DONE;
				else state_d = S_POP_RD;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = buf_rdata[MW+VALUE_BITS-1:VALUE_BITS];
		mem_wdata = buf_rdata[VALUE_BITS-1:0];
		mem_raddr = cell_q;
		buf_we    = 1'b0;
		buf_waddr = {thr_q, wrap(cur_head, cur_cnt)};
		buf_wdata = {cell_q, val_q};
		buf_raddr = {thr_q, wrap(cur_head, k_q - CW'(1))};
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_WR:     buf_we = thr_ok_q && !cur_full;
			S_POP_RD: buf_raddr = {thr_q, cur_head};
			S_POP_WAIT: buf_raddr = {thr_q, cur_head};
			S_POP_WR: mem_we = 1'b1;
			default: ;
		endcase
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			for (int i = 0; i < THREADS; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLEAR: clr_q <= clr_q + MW'(1);
				S_WR: if (thr_ok_q && !cur_full) cnt_q[thr_q] <= cur_cnt + CW'(1);
				S_POP_WR: begin
					head_q[thr_q] <= wrap(cur_head, CW'(1));
					cnt_q[thr_q]  <= cur_cnt - CW'(1);
				end
				default: ;
			endcase
		end
	end

	// payload and sequencing registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				thr_q    <= (req.action == ACT_FENCE) ? '0 : in_thr;
				thr_ok_q <= in_thr_ok;
				cell_q   <= in_cell;
				val_q    <= VALUE_BITS'(req.store_value);
				drain_q  <= (req.action == ACT_FENCE) ||
					(req.action == ACT_WRITE && req.seq_cst);
				any_q    <= 1'b0;
				data_q   <= '0;
				fwd_q    <= 1'b0;
				st_q     <= (req.action == ACT_PROP && !(in_thr_ok && cnt_q[in_thr] != '0))
					? ST_EMPTY : ST_OK;
			end
			S_RD_MEM: k_q <= cur_cnt;
			S_RD_SCAN: if (k_q == '0 || !thr_ok_q) data_q <= mem_rdata;
			S_RD_WAIT: k_q <= k_q - CW'(1);
			S_RD_CMP: if (buf_rdata[MW+VALUE_BITS-1:VALUE_BITS] == cell_q) begin
				data_q <= buf_rdata[VALUE_BITS-1:0];
				fwd_q  <= 1'b1;
			end
			S_WR: begin
				if (!thr_ok_q || cur_full) st_q <= ST_FULL;
				thr_q <= '0;
				any_q <= 1'b0;
			end
			S_POP_RD: if (cur_cnt == '0) begin
				if (last_thr) begin
					thr_q <= '0;
					any_q <= 1'b0;
				end else begin
					thr_q <= thr_q + TW'(1);
				end
			end
			S_POP_WR: begin
				if (last_thr) begin
					thr_q <= '0;
					any_q <= 1'b0;
				end else begin
					thr_q <= thr_q + TW'(1);
					any_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	always_comb begin
		rsp           = '0;
		rsp.read_data = 64'(data_q);
		rsp.forwarded = fwd_q;
		rsp.status    = st_q;
	end
endmodule

// ===== rtl/core/tso_checker.sv =====
// Port checker for the store buffer memory core, bound to the top level.
module tso_checker
	import tso_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input tso_rsp_t rsp
);
	// a result is only shown while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");

	// busy drops right after a result
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");

	// an accepted request keeps the block busy
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not held");

	// forwarding only reports ok status
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.forwarded) |-> (rsp.status == ST_OK)) else $error("bad fwd status");
endmodule

bind tso_store_buffer_memory_core tso_checker u_tso_checker (
	.clk(clk), .arst_n(arst_n), .start(start),
	.busy(busy), .done(done), .rsp(rsp)
);

// ===== tb/testbench.sv =====
// Testbench of the TSO store buffer memory core: directed and random requests, checked per result.
module testbench;
	import tso_pkg::*;

	localparam int NTHR  = 4;
	localparam int DEPTH = 8;
	localparam int CELLS = 256;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int EXP_DEPTH = 16;

	logic     clk;
	logic     arst_n;
	logic     start;
	tso_req_t req;
	logic     busy;
	logic     done;
	tso_rsp_t rsp;

	tso_store_buffer_memory_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	// Predictor state
	logic [63:0] mem_model [CELLS];
	logic [7:0]  sb_addr [NTHR][DEPTH];
	logic [63:0] sb_val [NTHR][DEPTH];
	int unsigned sb_head [NTHR];
	int unsigned sb_count [NTHR];

	// expected results, written at acceptance, read at each result
	tso_rsp_t    exp_buf [EXP_DEPTH];
	int unsigned exp_wr = 0;
	int unsigned exp_rd = 0;
	bit          failed = 1'b0;
	int          idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Move the oldest entry of one thread into memory
	function automatic void pop_entry(int t);
		int h;
		h = sb_head[t];
		mem_model[sb_addr[t][h]] = sb_val[t][h];
		sb_head[t] = (h + 1) % DEPTH;
		sb_count[t]--;
	endfunction

	// Drain all buffers round by round, ascending thread order
	function automatic void drain_buffers();
		bit any;
		any = 1'b1;
		while (any) begin
			any = 1'b0;
			for (int t = 0; t < NTHR; t++) begin
				if (sb_count[t] != 0) begin
					pop_entry(t);
					any = 1'b1;
				end
			end
		end
	endfunction

	function automatic tso_rsp_t predict_rsp(tso_req_t r);
		tso_rsp_t o;
		int t;
		int idx;
		o = '0;
		t = r.thread;
		case (r.action)
			ACT_READ: begin
				o.read_data = mem_model[r.address];
				for (int k = int'(sb_count[t]) - 1; k >= 0; k--) begin
					idx = (sb_head[t] + k) % DEPTH;
					if (sb_addr[t][idx] == r.address) begin
						o.read_data = sb_val[t][idx];
						o.forwarded = 1'b1;
						break;
					end
				end
			end
			ACT_WRITE: begin
				if (sb_count[t] >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					idx = (sb_head[t] + sb_count[t]) % DEPTH;
					sb_addr[t][idx] = r.address;
					sb_val[t][idx] = r.store_value;
					sb_count[t]++;
					if (r.seq_cst) drain_buffers();
				end
			end
			ACT_PROP: begin
				if (sb_count[t] == 0) o.status = ST_EMPTY;
				else pop_entry(t);
			end
			default: drain_buffers();
		endcase
		return o;
	endfunction

	// Send one request after a random gap
	task automatic send_request(tso_req_t r);
		int gap;
		gap = $urandom_range(0, 17);
		if ($urandom_range(0, 3) == 0) gap = 0;
		// leave the edge that ended the previous request
		@(posedge clk);
		repeat (gap) @(posedge clk);
		req   <= r;
		start <= 1'b1;
		// wait until the block is free; the next rising edge takes the request
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		start <= 1'b0;
		exp_buf[exp_wr % EXP_DEPTH] = predict_rsp(r);
		exp_wr++;
	endtask

	function automatic tso_req_t make_req(logic [1:0] a, logic [1:0] t, logic [7:0] ad,
		logic [63:0] v, logic sc);
		tso_req_t r;
		r.action = a; r.thread = t; r.address = ad; r.store_value = v; r.seq_cst = sc;
		return r;
	endfunction

	function automatic logic [63:0] rand_value();
		return {$urandom, $urandom};
	endfunction

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		tso_rsp_t e;
		if (arst_n && done) begin
			if (exp_wr == exp_rd) begin
				$display("%0t unexpected result: expected none actual %h", $time, rsp);
				failed = 1'b1;
			end else begin
				e = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (rsp.read_data !== e.read_data) begin
					$display("%0t read_data: expected %h actual %h", $time,
						e.read_data, rsp.read_data);
					failed = 1'b1;
				end
				if (rsp.forwarded !== e.forwarded) begin
					$display("%0t forwarded: expected %b actual %b", $time,
						e.forwarded, rsp.forwarded);
					failed = 1'b1;
				end
				if (rsp.status !== e.status) begin
					$display("%0t status: expected %0d actual %0d", $time,
						e.status, rsp.status);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog on cycles without any request or result accepted
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tso_store_buffer_memory_core: mismatch");
			$finish;
		end
	end

	// Directed: extremes, every action, full and empty buffers
	task automatic test_directed();
		send_request(make_req(ACT_READ, 2'd0, 8'hff, '0, 1'b0));
		send_request(make_req(ACT_PROP, 2'd3, 8'h00, '0, 1'b0));
		send_request(make_req(ACT_WRITE, 2'd0, 8'hff, '1, 1'b0));
		send_request(make_req(ACT_WRITE, 2'd0, 8'hff, 64'h5a5a_0000_ffff_1234, 1'b0));
		send_request(make_req(ACT_READ, 2'd0, 8'hff, '0, 1'b0));
		send_request(make_req(ACT_READ, 2'd1, 8'hff, '0, 1'b0));
		for (int i = 0; i < DEPTH; i++)
			send_request(make_req(ACT_WRITE, 2'd3, 8'(i), rand_value(), 1'b0));
		send_request(make_req(ACT_WRITE, 2'd3, 8'h00, '1, 1'b1));
		send_request(make_req(ACT_PROP, 2'd3, 8'h00, '0, 1'b0));
		send_request(make_req(ACT_READ, 2'd3, 8'h00, '1, 1'b1));
		send_request(make_req(ACT_FENCE, 2'd2, 8'h10, '1, 1'b1));
		send_request(make_req(ACT_READ, 2'd1, 8'hff, '0, 1'b0));
		send_request(make_req(ACT_WRITE, 2'd2, 8'h00, 64'h0, 1'b1));
		send_request(make_req(ACT_READ, 2'd0, 8'h00, '0, 1'b0));
	endtask

	// Random: mostly writes and reads on a small address pool to hit forwarding
	task automatic test_random(int n);
		tso_req_t r;
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			r.thread = 2'($urandom);
			r.address = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			r.store_value = rand_value();
			r.seq_cst = ($urandom_range(0, 19) == 0);
			if (p < 45) r.action = ACT_WRITE;
			else if (p < 80) r.action = ACT_READ;
			else if (p < 96) r.action = ACT_PROP;
			else r.action = ACT_FENCE;
			if (r.action != ACT_WRITE && $urandom_range(0, 1)) r.seq_cst = 1'b1;
			send_request(r);
		end
	endtask

	initial begin
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		for (int i = 0; i < CELLS; i++) mem_model[i] = '0;
		for (int t = 0; t < NTHR; t++) begin
			sb_head[t] = 0;
			sb_count[t] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1000);
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (200) @(posedge clk);
		if (!failed && exp_wr == exp_rd)
			$display("tso_store_buffer_memory_core: match");
		else
			$display("tso_store_buffer_memory_core: mismatch");
		$finish;
	end
endmodule
